@@ sv/aff_pkg.sv @@
// Shared types and constants for the AMQP frame filter.
// Holds the verdict codes, frame type codes and the known-method table.
// No dependencies.
package aff_pkg;

   typedef enum logic [1:0] {
      VERDICT_PASS  = 2'd0,
      VERDICT_TRASH = 2'd1,
      VERDICT_KILL  = 2'd2
   } verdict_type;

   typedef struct packed {
      verdict_type verdict;
      logic        msg_inc;
      logic        body_add;
   } step_type;

   localparam logic [7:0] FT_METHOD    = 8'd1;
   localparam logic [7:0] FT_HEADER    = 8'd2;
   localparam logic [7:0] FT_BODY      = 8'd3;
   localparam logic [7:0] FT_HEARTBEAT = 8'd8;

   localparam logic [31:0] PREFIX_RESET = 32'h4841_434B;
   localparam logic [7:0]  MIN_MATCH_LEN = 8'd4;
   localparam logic [31:0] MIN_BODY_LEN  = 32'd4;

   localparam logic [31:0] KEY_EXCH_DECLARE  = 32'h0028_000A;
   localparam logic [31:0] KEY_QUEUE_DECLARE = 32'h0032_000A;

   localparam int ROM_SIZE = 55;

   // class in the upper half, method in the lower half
   localparam logic [31:0] METHOD_ROM [ROM_SIZE] = '{
      32'h000A000A, 32'h000A000B, 32'h000A0014, 32'h000A0015, 32'h000A001E,
      32'h000A001F, 32'h000A0028, 32'h000A0029, 32'h000A0032, 32'h000A0033,
      32'h0014000A, 32'h0014000B, 32'h00140014, 32'h00140015, 32'h00140028,
      32'h00140029,
      32'h0028000A, 32'h0028000B, 32'h00280014, 32'h00280015,
      32'h0032000A, 32'h0032000B, 32'h00320014, 32'h00320015, 32'h00320032,
      32'h00320033, 32'h0032001E, 32'h0032001F, 32'h00320028, 32'h00320029,
      32'h003C000A, 32'h003C000B, 32'h003C0014, 32'h003C0015, 32'h003C001E,
      32'h003C001F, 32'h003C0028, 32'h003C0032, 32'h003C003C, 32'h003C0046,
      32'h003C0047, 32'h003C0048, 32'h003C0050, 32'h003C005A, 32'h003C0064,
      32'h003C006E, 32'h003C006F,
      32'h0055000A, 32'h0055000B,
      32'h005A000A, 32'h005A000B, 32'h005A0014, 32'h005A0015, 32'h005A001E,
      32'h005A001F
   };

   function automatic logic rom_has(input logic [31:0] key);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < ROM_SIZE; i++) begin
         hit = hit | (METHOD_ROM[i] == key);
      end
      return hit;
   endfunction

endpackage

@@ sv/aff_verdict.sv @@
// Per-frame classification for the AMQP frame filter.
// Decides the verdict and which running total a frame touches.
// Depends on aff_pkg.
module aff_verdict (
   input  logic              inbound,
   input  logic [7:0]        frame_type,
   input  logic [15:0]       class_id,
   input  logic [15:0]       method_id,
   input  logic [31:0]       frame_size,
   input  logic [7:0]        name_length,
   input  logic [31:0]       head_bytes,
   input  logic [31:0]       prefix,
   output aff_pkg::step_type step
);

   logic [31:0] key;
   logic        prefix_hit;
   logic        is_declare;

   assign key        = {class_id, method_id};
   assign prefix_hit = (head_bytes == prefix);
   assign is_declare = (key == aff_pkg::KEY_EXCH_DECLARE) ||
                       (key == aff_pkg::KEY_QUEUE_DECLARE);

   always_comb begin
      step.verdict  = aff_pkg::VERDICT_TRASH;
      step.msg_inc  = 1'b0;
      step.body_add = 1'b0;
      case (frame_type)
         aff_pkg::FT_METHOD: begin
            if (!aff_pkg::rom_has(key)) begin
               step.verdict = aff_pkg::VERDICT_TRASH;
            end else if (inbound && is_declare && prefix_hit &&
                         (name_length >= aff_pkg::MIN_MATCH_LEN)) begin
               step.verdict = aff_pkg::VERDICT_KILL;
            end else begin
               step.verdict = aff_pkg::VERDICT_PASS;
            end
         end
         aff_pkg::FT_HEADER: begin
            step.verdict = aff_pkg::VERDICT_PASS;
            step.msg_inc = 1'b1;
         end
         aff_pkg::FT_BODY: begin
            step.body_add = 1'b1;
            if (prefix_hit && (frame_size >= aff_pkg::MIN_BODY_LEN)) begin
               step.verdict = aff_pkg::VERDICT_KILL;
            end else begin
               step.verdict = aff_pkg::VERDICT_PASS;
            end
         end
         aff_pkg::FT_HEARTBEAT: begin
            step.verdict = aff_pkg::VERDICT_PASS;
         end
         default: begin
            step.verdict = aff_pkg::VERDICT_TRASH;
         end
      endcase
   end

endmodule

@@ sv/amqp_frame_filter.sv @@
// Top level of the AMQP frame filter: request register, verdict logic,
// running totals and response register. Depends on aff_pkg, aff_verdict.
//
//   channel | ports              | handshake
//   --------+--------------------+-------------------------------
//   request | req_*              | req_valid / req_ready
//   result  | rsp_*              | rsp_valid / rsp_ready
//   config  | csr_wr_en/_data    | write on csr_wr_en, no wait
//
// Result registered after the request stage; if rsp_ready, one request per cycle
// sustained. The single adder pass over the 64-bit byte total sets the path.
// Synchronous active-high reset clears both totals and valids, reloads the prefix.
// A stalled response holds the result stage; the request stage drains into
// it the cycle it frees, so ready drops only when both stages are full.
module amqp_frame_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_inbound,
   input  logic [7:0]  req_frame_type,
   input  logic [15:0] req_class_id,
   input  logic [15:0] req_method_id,
   input  logic [31:0] req_frame_size,
   input  logic [7:0]  req_name_length,
   input  logic [31:0] req_head_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_messages_seen,
   output logic [63:0] rsp_body_bytes_seen,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic        s1_valid_ff;
   logic        s1_inbound_ff;
   logic [7:0]  s1_frame_type_ff;
   logic [15:0] s1_class_id_ff;
   logic [15:0] s1_method_id_ff;
   logic [31:0] s1_frame_size_ff;
   logic [7:0]  s1_name_length_ff;
   logic [31:0] s1_head_bytes_ff;
   logic [31:0] prefix_ff;
   logic [31:0] msg_total_ff;
   logic [63:0] body_total_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_verdict_ff;
   logic [31:0] rsp_msg_ff;
   logic [63:0] rsp_body_ff;

   logic [31:0] msg_total_in;
   logic [63:0] body_total_in;
   logic        rsp_free;
   logic        s1_advance;

   aff_pkg::step_type step;

   aff_verdict u_verdict (
      .inbound     (s1_inbound_ff),
      .frame_type  (s1_frame_type_ff),
      .class_id    (s1_class_id_ff),
      .method_id   (s1_method_id_ff),
      .frame_size  (s1_frame_size_ff),
      .name_length (s1_name_length_ff),
      .head_bytes  (s1_head_bytes_ff),
      .prefix      (prefix_ff),
      .step        (step)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_ready  = !s1_valid_ff || rsp_free;

   assign msg_total_in  = msg_total_ff + {31'd0, step.msg_inc};
   assign body_total_in = step.body_add ? (body_total_ff + {32'd0, s1_frame_size_ff})
                                        : body_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prefix_ff     <= aff_pkg::PREFIX_RESET;
         msg_total_ff  <= 32'd0;
         body_total_ff <= 64'd0;
      end else begin
         if (csr_wr_en) begin
            prefix_ff <= csr_wr_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_advance) begin
            msg_total_ff  <= msg_total_in;
            body_total_ff <= body_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_inbound_ff     <= req_inbound;
         s1_frame_type_ff  <= req_frame_type;
         s1_class_id_ff    <= req_class_id;
         s1_method_id_ff   <= req_method_id;
         s1_frame_size_ff  <= req_frame_size;
         s1_name_length_ff <= req_name_length;
         s1_head_bytes_ff  <= req_head_bytes;
      end
      if (s1_advance) begin
         rsp_verdict_ff <= step.verdict;
         rsp_msg_ff     <= msg_total_in;
         rsp_body_ff    <= body_total_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_messages_seen   = rsp_msg_ff;
   assign rsp_body_bytes_seen = rsp_body_ff;

endmodule

@@ sv/aff_checker.sv @@
// Port-level checks for the AMQP frame filter, bound to the top level.
// Depends on aff_pkg and amqp_frame_filter.
module aff_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_verdict,
   input logic [31:0] rsp_messages_seen,
   input logic [63:0] rsp_body_bytes_seen
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
      $stable(rsp_messages_seen) && $stable(rsp_body_bytes_seen))
      else $error("response changed while stalled");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == aff_pkg::VERDICT_PASS) ||
                    (rsp_verdict == aff_pkg::VERDICT_TRASH) ||
                    (rsp_verdict == aff_pkg::VERDICT_KILL))
      else $error("undefined verdict code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_msg_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) ##1 rsp_valid |->
      (rsp_messages_seen == $past(rsp_messages_seen)) ||
      (rsp_messages_seen == $past(rsp_messages_seen) + 32'd1))
      else $error("message count moved by more than one between responses");

endmodule

bind amqp_frame_filter aff_checker u_aff_checker (.*);

@@ test/tb_top.sv @@
// Testbench for amqp_frame_filter: a directed frame table, then random frames
// under several blocked prefixes, every response checked against a local predictor.
// Depends on aff_pkg and the amqp_frame_filter RTL.
module tb_top;

   localparam logic [15:0] CLASS_CONNECTION  = 16'd10;
   localparam logic [15:0] CLASS_CHANNEL     = 16'd20;
   localparam logic [15:0] CLASS_EXCHANGE    = 16'd40;
   localparam logic [15:0] CLASS_QUEUE       = 16'd50;
   localparam logic [15:0] CLASS_BASIC       = 16'd60;
   localparam logic [15:0] CLASS_CONFIRM     = 16'd85;
   localparam logic [15:0] CLASS_TX          = 16'd90;
   localparam logic [15:0] METHOD_DECLARE    = 16'd10;
   localparam logic [15:0] METHOD_DECLARE_OK = 16'd11;

   localparam int FRAMES_PER_PHASE = 115;
   localparam int LONG_HOLD        = 40;
   localparam int IDLE_LIMIT       = 1000;

   typedef struct {
      logic                 inbound;
      logic [7:0]           frame_type;
      logic [15:0]          class_id;
      logic [15:0]          method_id;
      logic [31:0]          frame_size;
      logic [7:0]           name_length;
      logic [31:0]          head_bytes;
      logic                 typed;
      aff_pkg::verdict_type verdict;
   } frame_item_type;

   typedef struct {
      aff_pkg::verdict_type verdict;
      logic [31:0]          messages;
      logic [63:0]          body_bytes;
   } frame_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_messages_seen;
   logic [63:0] rsp_body_bytes_seen;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;

   frame_item_type cur = '{1'b0, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0, 32'd0, 1'b0,
                           aff_pkg::VERDICT_PASS};

   logic [31:0]       prefix_cfg = aff_pkg::PREFIX_RESET;
   logic [31:0]       header_total = 32'd0;
   logic [63:0]       body_total = 64'd0;
   frame_verdict_type verdicts_due [$];

   int errors = 0;
   int idle_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_requests = 0;
   int holds_taken = 0;
   int hold_left = 0;

   frame_item_type directed_rows [22] = '{
      '{1'b0, aff_pkg::FT_HEARTBEAT, 16'd0, 16'd0, 32'd0, 8'd0, 32'd0,
        1'b1, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_HEADER, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
        1'b0, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_BODY, 16'd0, 16'd0, 32'd0, 8'd0, aff_pkg::PREFIX_RESET,
        1'b1, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_BODY, 16'd0, 16'd0, 32'd3, 8'd0, aff_pkg::PREFIX_RESET,
        1'b1, aff_pkg::VERDICT_PASS},
      '{1'b0, aff_pkg::FT_BODY, 16'd0, 16'd0, 32'd4, 8'd0, aff_pkg::PREFIX_RESET,
        1'b1, aff_pkg::VERDICT_KILL},
      '{1'b1, aff_pkg::FT_BODY, 16'd0, 16'd0, 32'hFFFF_FFFF, 8'd0, 32'd0,
        1'b1, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_BODY, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
        1'b0, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_EXCHANGE, METHOD_DECLARE, 32'd20, 8'd4,
        aff_pkg::PREFIX_RESET, 1'b1, aff_pkg::VERDICT_KILL},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_QUEUE, METHOD_DECLARE, 32'd300, 8'd255,
        aff_pkg::PREFIX_RESET, 1'b1, aff_pkg::VERDICT_KILL},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_EXCHANGE, METHOD_DECLARE, 32'd20, 8'd3,
        aff_pkg::PREFIX_RESET, 1'b1, aff_pkg::VERDICT_PASS},
      '{1'b0, aff_pkg::FT_METHOD, CLASS_EXCHANGE, METHOD_DECLARE, 32'd20, 8'd4,
        aff_pkg::PREFIX_RESET, 1'b1, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_EXCHANGE, METHOD_DECLARE_OK, 32'd20, 8'd4,
        aff_pkg::PREFIX_RESET, 1'b1, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_CONNECTION, METHOD_DECLARE, 32'd20, 8'd4,
        aff_pkg::PREFIX_RESET, 1'b0, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_METHOD, 16'hFFFF, 16'hFFFF, 32'd0, 8'd0, 32'd0,
        1'b1, aff_pkg::VERDICT_TRASH},
      '{1'b0, aff_pkg::FT_METHOD, 16'h0000, 16'h0000, 32'd0, 8'd0, 32'd0,
        1'b1, aff_pkg::VERDICT_TRASH},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_QUEUE, METHOD_DECLARE, 32'd20, 8'd4, 32'h4841_434A,
        1'b0, aff_pkg::VERDICT_PASS},
      '{1'b1, 8'd0, 16'd0, 16'd0, 32'd8, 8'd0, aff_pkg::PREFIX_RESET,
        1'b1, aff_pkg::VERDICT_TRASH},
      '{1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 32'd8, 8'hFF, aff_pkg::PREFIX_RESET,
        1'b1, aff_pkg::VERDICT_TRASH},
      '{1'b0, 8'd4, 16'd0, 16'd0, 32'd8, 8'd0, aff_pkg::PREFIX_RESET,
        1'b1, aff_pkg::VERDICT_TRASH},
      '{1'b1, aff_pkg::FT_METHOD, CLASS_TX, 16'd31, 32'd4, 8'd0, 32'd0,
        1'b0, aff_pkg::VERDICT_PASS},
      '{1'b0, aff_pkg::FT_HEADER, 16'd0, 16'd0, 32'd14, 8'd0, 32'd0,
        1'b0, aff_pkg::VERDICT_PASS},
      '{1'b1, aff_pkg::FT_HEARTBEAT, CLASS_QUEUE, METHOD_DECLARE, 32'd4, 8'd4,
        aff_pkg::PREFIX_RESET, 1'b0, aff_pkg::VERDICT_PASS}
   };

   amqp_frame_filter u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_inbound         (cur.inbound),
      .req_frame_type      (cur.frame_type),
      .req_class_id        (cur.class_id),
      .req_method_id       (cur.method_id),
      .req_frame_size      (cur.frame_size),
      .req_name_length     (cur.name_length),
      .req_head_bytes      (cur.head_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_verdict         (rsp_verdict),
      .rsp_messages_seen   (rsp_messages_seen),
      .rsp_body_bytes_seen (rsp_body_bytes_seen),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic known_method(input logic [15:0] cls, input logic [15:0] mtd);
      logic hit;
      hit = 1'b0;
      case (cls)
         CLASS_CONNECTION: begin
            case (mtd)
               16'd10, 16'd11, 16'd20, 16'd21, 16'd30, 16'd31, 16'd40, 16'd41, 16'd50,
               16'd51: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         CLASS_CHANNEL: begin
            case (mtd)
               16'd10, 16'd11, 16'd20, 16'd21, 16'd40, 16'd41: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         CLASS_EXCHANGE: begin
            case (mtd)
               16'd10, 16'd11, 16'd20, 16'd21: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         CLASS_QUEUE: begin
            case (mtd)
               16'd10, 16'd11, 16'd20, 16'd21, 16'd30, 16'd31, 16'd40, 16'd41, 16'd50,
               16'd51: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         CLASS_BASIC: begin
            case (mtd)
               16'd10, 16'd11, 16'd20, 16'd21, 16'd30, 16'd31, 16'd40, 16'd50, 16'd60,
               16'd70, 16'd71, 16'd72, 16'd80, 16'd90, 16'd100, 16'd110,
               16'd111: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         CLASS_CONFIRM: begin
            case (mtd)
               16'd10, 16'd11: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         CLASS_TX: begin
            case (mtd)
               16'd10, 16'd11, 16'd20, 16'd21, 16'd30, 16'd31: hit = 1'b1;
               default: hit = 1'b0;
            endcase
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   task automatic predict_frame(input frame_item_type f, output frame_verdict_type r);
      r.verdict = aff_pkg::VERDICT_PASS;
      case (f.frame_type)
         aff_pkg::FT_METHOD: begin
            if (!known_method(f.class_id, f.method_id)) begin
               r.verdict = aff_pkg::VERDICT_TRASH;
            end else if (f.inbound && f.method_id == METHOD_DECLARE &&
                         (f.class_id == CLASS_EXCHANGE || f.class_id == CLASS_QUEUE) &&
                         f.name_length >= 8'd4 && f.head_bytes == prefix_cfg) begin
               r.verdict = aff_pkg::VERDICT_KILL;
            end
         end
         aff_pkg::FT_HEADER: header_total = header_total + 32'd1;
         aff_pkg::FT_BODY: begin
            body_total = body_total + {32'd0, f.frame_size};
            if (f.frame_size >= 32'd4 && f.head_bytes == prefix_cfg) begin
               r.verdict = aff_pkg::VERDICT_KILL;
            end
         end
         aff_pkg::FT_HEARTBEAT: r.verdict = aff_pkg::VERDICT_PASS;
         default: r.verdict = aff_pkg::VERDICT_TRASH;
      endcase
      r.messages = header_total;
      r.body_bytes = body_total;
   endtask

   function automatic frame_item_type random_frame();
      frame_item_type f;
      int pick;
      f.typed = 1'b0;
      f.verdict = aff_pkg::VERDICT_PASS;
      f.inbound = ($urandom_range(3) != 0);
      pick = $urandom_range(99);
      if (pick < 45) f.frame_type = aff_pkg::FT_METHOD;
      else if (pick < 55) f.frame_type = aff_pkg::FT_HEADER;
      else if (pick < 80) f.frame_type = aff_pkg::FT_BODY;
      else if (pick < 88) f.frame_type = aff_pkg::FT_HEARTBEAT;
      else f.frame_type = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 30) begin
         f.class_id = ($urandom_range(1) != 0) ? CLASS_EXCHANGE : CLASS_QUEUE;
         f.method_id = METHOD_DECLARE;
      end else if (pick < 80) begin
         case ($urandom_range(6))
            0: f.class_id = CLASS_CONNECTION;
            1: f.class_id = CLASS_CHANNEL;
            2: f.class_id = CLASS_EXCHANGE;
            3: f.class_id = CLASS_QUEUE;
            4: f.class_id = CLASS_BASIC;
            5: f.class_id = CLASS_CONFIRM;
            default: f.class_id = CLASS_TX;
         endcase
         f.method_id = 16'(10 * $urandom_range(1, 11) + $urandom_range(1));
      end else begin
         f.class_id = 16'($urandom);
         f.method_id = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 40) f.head_bytes = prefix_cfg;
      else if (pick < 55) f.head_bytes = prefix_cfg ^ (32'd1 << $urandom_range(31));
      else f.head_bytes = $urandom;
      f.frame_size = ($urandom_range(99) < 35) ? 32'($urandom_range(6)) : $urandom;
      f.name_length = ($urandom_range(99) < 30) ? 8'($urandom_range(5))
                                                : 8'($urandom_range(255));
      return f;
   endfunction

   task automatic offer_frame(input frame_item_type f);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      cur = f;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_prefix(input logic [31:0] value);
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      prefix_cfg = value;
   endtask

   // receiver: random stalls, plus long hold-offs on request from the main flow
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready = 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken = holds_taken + 1;
         hold_left = LONG_HOLD - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : monitor
      frame_verdict_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_frame(cur, want);
            if (cur.typed) want.verdict = cur.verdict;
            verdicts_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected response, verdict %0d messages %0d bytes %0d",
                        $time, rsp_verdict, rsp_messages_seen, rsp_body_bytes_seen);
               errors = errors + 1;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  $display("%0t: verdict expected %0d actual %0d",
                           $time, want.verdict, rsp_verdict);
                  errors = errors + 1;
               end
               if (rsp_messages_seen !== want.messages) begin
                  $display("%0t: messages_seen expected %0d actual %0d",
                           $time, want.messages, rsp_messages_seen);
                  errors = errors + 1;
               end
               if (rsp_body_bytes_seen !== want.body_bytes) begin
                  $display("%0t: body_bytes_seen expected %0d actual %0d",
                           $time, want.body_bytes, rsp_body_bytes_seen);
                  errors = errors + 1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
            $display("** amqp_frame_filter: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] prefix;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      send_idle = 37;
      recv_idle = 74;
      foreach (directed_rows[i]) offer_frame(directed_rows[i]);
      req_valid = 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: prefix = 32'h0000_0000;
            1: prefix = 32'hFFFF_FFFF;
            4: prefix = aff_pkg::PREFIX_RESET;
            default: prefix = $urandom;
         endcase
         write_prefix(prefix);
         send_idle = (phase < 2) ? 37 : (phase < 4) ? 74 : 0;
         recv_idle = (phase < 2) ? 74 : (phase < 4) ? 37 : 0;
         // fill the pipeline against a stalled response side
         if (phase == 1 || phase == 4) hold_requests <= hold_requests + 1;
         repeat (FRAMES_PER_PHASE) offer_frame(random_frame());
         req_valid = 1'b0;
      end
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("** amqp_frame_filter: PASSED **");
      end else begin
         $display("** amqp_frame_filter: FAILED **");
      end
      $finish;
   end

endmodule
